FILE: sv/wpom_pkg.sv
// Shared types, codes and character helpers of the word pattern matcher.
// Used by wpom_cell and word_pattern_occurrence_matcher_top; no dependencies.
package wpom_pkg;

    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int OCC_W    = 4;
    localparam int POS_W    = 32;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CHAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_END  = 2'd2;

    // Control broadcast from the top level to every pattern cell.
    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic              char_step;
        logic              word_end;
        logic              advance;
    } cell_ctrl_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Space, punctuation, backslash, double quote, CR, LF and NUL.
    function automatic logic is_delim(input logic [7:0] c);
        logic hit;
        hit = (c == 8'h00) || (c == 8'h0A) || (c == 8'h0D)
            || (c >= 8'h20 && c <= 8'h2F)
            || (c >= 8'h3A && c <= 8'h40)
            || (c >= 8'h5B && c <= 8'h60)
            || (c >= 8'h7B && c <= 8'h7E);
        return hit;
    endfunction

endpackage

FILE: sv/word_pattern_occurrence_matcher_top.sv
// Word ends set pending bits in matching cells, read out by the output register.
// Throughput: one transaction per cycle while s_ready is high; s_ready stays low
// while reports are pending, one report per cycle unless m_ready stalls.
// Reset (aresetn low, synchronous) clears counts, flags, window, word counter and
// pattern_count; the pattern table is not cleared and must be loaded before use.
// Depends on wpom_pkg and wpom_cell.
module word_pattern_occurrence_matcher_top #(
    parameter int PATTERNS         = 16,
    parameter int PATTERN_CHARS    = 4,
    parameter int KEEP_PER_PATTERN = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wpom_pkg::ACTION_W-1:0]   s_action,
    input  logic [7:0]                      s_character,
    input  logic [wpom_pkg::SLOT_W-1:0]     s_pattern_slot,
    input  logic [31:0]                     s_pattern_text,
    input  logic [2:0]                      s_pattern_length,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wpom_pkg::INDEX_W-1:0]    m_pattern_index,
    output logic [wpom_pkg::POS_W-1:0]      m_word_position,
    output logic [wpom_pkg::OCC_W-1:0]      m_occurrence_number,
    output logic                            m_last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int LEN_W = $clog2(PATTERN_CHARS + 1);

    // ------------------------------------------------------------------
    // Configuration: a single register, pattern_count, at byte addresses 0 to 3.
    // ------------------------------------------------------------------
    logic [wpom_pkg::COUNT_W-1:0] pattern_count_reg, pattern_count_next;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {27'b0, pattern_count_reg} : 32'b0;

    always_comb begin
        pattern_count_next = pattern_count_reg;
        if (cfg_write) begin
            pattern_count_next = pwdata[wpom_pkg::COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input side: classify the transaction and advance the word window.
    // ------------------------------------------------------------------
    logic                         accept, is_char, delim;
    logic                         char_step, word_end;
    logic [8*PATTERN_CHARS-1:0]   window_reg, window_next;
    logic [LEN_W-1:0]             chars_reg, chars_next;
    logic [wpom_pkg::POS_W-1:0]   word_counter_reg, word_counter_next;
    logic [8*PATTERN_CHARS-1:0]   pat_bytes;
    logic [LEN_W-1:0]             pat_len;
    logic [63:0]                  text_wide;
    logic [PATTERNS-1:0]          pend_vec, sel_vec;
    logic                         any_pend;

    assign any_pend = |pend_vec;
    // Hold off new transactions while a word end still has reports to hand out.
    assign s_ready  = !any_pend;
    assign accept   = s_valid && s_ready;
    assign is_char  = accept && (s_action == wpom_pkg::ACT_CHAR);
    assign delim    = wpom_pkg::is_delim(s_character);
    assign char_step = is_char && !delim;
    // A delimiter or end of text closes the word only if it holds characters.
    assign word_end = ((is_char && delim) || (accept && (s_action == wpom_pkg::ACT_END)))
                      && (chars_reg != '0);

    always_comb begin
        window_next       = window_reg;
        chars_next        = chars_reg;
        word_counter_next = word_counter_reg;
        if (char_step) begin
            // Newest character enters byte 0, oldest drops off the top.
            window_next = {window_reg[8*PATTERN_CHARS-1:0] << 8};
            window_next[7:0] = wpom_pkg::fold_char(s_character);
            if (int'(chars_reg) < PATTERN_CHARS) begin
                chars_next = chars_reg + 1'b1;
            end
        end
        if (word_end) begin
            window_next = '0;
            chars_next  = '0;
            if (word_counter_reg != '1) begin
                word_counter_next = word_counter_reg + 1'b1;
            end
        end
    end

    // Lowercase the pattern bytes and cut the length to the window size.
    always_comb begin
        text_wide = {32'b0, s_pattern_text};
        for (int k = 0; k < PATTERN_CHARS; k++) begin
            pat_bytes[8*k +: 8] = wpom_pkg::fold_char(text_wide[8*k +: 8]);
        end
        if (int'(s_pattern_length) > PATTERN_CHARS) begin
            pat_len = LEN_W'(PATTERN_CHARS);
        end else begin
            pat_len = LEN_W'(s_pattern_length);
        end
    end

    // ------------------------------------------------------------------
    // Row of pattern cells, chained by the "earlier cell pending" signal.
    // ------------------------------------------------------------------
    wpom_pkg::cell_ctrl_t         ctrl;
    logic                         out_free;
    logic                         m_valid_reg, m_valid_next;
    logic [PATTERNS:0]            chain;
    logic [wpom_pkg::OCC_W-1:0]   cell_count [PATTERNS];

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ctrl.load      = accept && (s_action == wpom_pkg::ACT_LOAD);
        ctrl.slot      = s_pattern_slot;
        ctrl.char_step = char_step;
        ctrl.word_end  = word_end;
        ctrl.advance   = out_free;
    end

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < PATTERNS; i++) begin : g_cell
        wpom_cell #(
            .IDX              (i),
            .PATTERN_CHARS    (PATTERN_CHARS),
            .KEEP_PER_PATTERN (KEEP_PER_PATTERN)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .ctrl          (ctrl),
            .pattern_count (pattern_count_reg),
            .pat_bytes     (pat_bytes),
            .pat_len       (pat_len),
            .window        (window_next),
            .word_chars    (chars_next),
            .prior_in      (chain[i]),
            .prior_out     (chain[i+1]),
            .pend          (pend_vec[i]),
            .sel           (sel_vec[i]),
            .count         (cell_count[i])
        );
    end

    // ------------------------------------------------------------------
    // Output register: take the lowest pending cell whenever it is free.
    // ------------------------------------------------------------------
    logic [wpom_pkg::INDEX_W-1:0] index_reg, index_next, sel_index;
    logic [wpom_pkg::POS_W-1:0]   position_reg, position_next;
    logic [wpom_pkg::OCC_W-1:0]   occ_reg, occ_next, sel_count;
    logic                         last_reg, last_next;

    always_comb begin
        sel_index = '0;
        sel_count = '0;
        for (int i = 0; i < PATTERNS; i++) begin
            if (sel_vec[i]) begin
                sel_index = sel_index | wpom_pkg::INDEX_W'(i);
                sel_count = sel_count | cell_count[i];
            end
        end
    end

    always_comb begin
        m_valid_next  = m_valid_reg;
        index_next    = index_reg;
        position_next = position_reg;
        occ_next      = occ_reg;
        last_next     = last_reg;
        if (out_free && any_pend) begin
            m_valid_next  = 1'b1;
            index_next    = sel_index;
            position_next = word_counter_reg;
            occ_next      = sel_count;
            // Last report of this word end when nothing else stays pending.
            last_next     = ((pend_vec & ~sel_vec) == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_pattern_index     = index_reg;
    assign m_word_position     = position_reg;
    assign m_occurrence_number = occ_reg;
    assign m_last              = last_reg;

    always_ff @(posedge aclk) begin
        index_reg    <= index_next;
        position_reg <= position_next;
        occ_reg      <= occ_next;
        last_reg     <= last_next;
        if (!aresetn) begin
            pattern_count_reg <= '0;
            window_reg        <= '0;
            chars_reg         <= '0;
            word_counter_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            pattern_count_reg <= pattern_count_next;
            window_reg        <= window_next;
            chars_reg         <= chars_next;
            word_counter_reg  <= word_counter_next;
            m_valid_reg       <= m_valid_next;
        end
    end

endmodule

FILE: sv/wpom_cell.sv
// One pattern cell: stored pattern, sticky match flag, occurrence count and
// pending report bit, with a priority chain to its neighbours. Uses wpom_pkg.
module wpom_cell #(
    parameter int IDX              = 0,
    parameter int PATTERN_CHARS    = 4,
    parameter int KEEP_PER_PATTERN = 10
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  wpom_pkg::cell_ctrl_t               ctrl,
    input  logic [wpom_pkg::COUNT_W-1:0]       pattern_count,
    input  logic [8*PATTERN_CHARS-1:0]         pat_bytes,
    input  logic [$clog2(PATTERN_CHARS+1)-1:0] pat_len,
    input  logic [8*PATTERN_CHARS-1:0]         window,
    input  logic [$clog2(PATTERN_CHARS+1)-1:0] word_chars,
    input  logic                               prior_in,
    output logic                               prior_out,
    output logic                               pend,
    output logic                               sel,
    output logic [wpom_pkg::OCC_W-1:0]         count
);

    localparam int LEN_W = $clog2(PATTERN_CHARS + 1);

    // Pattern stored reversed: byte j pairs with window byte j (newest first).
    logic [8*PATTERN_CHARS-1:0] rev_reg, rev_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [wpom_pkg::OCC_W-1:0] count_reg, count_next;
    logic                       flag_reg, flag_next;
    logic                       pend_reg, pend_next;
    logic                       active, hit, match, mismatch;

    always_comb begin
        active = (32'(pattern_count) > IDX);
        hit    = ctrl.load && (32'(ctrl.slot) == IDX);
        mismatch = 1'b0;
        for (int j = 0; j < PATTERN_CHARS; j++) begin
            if (j < int'(len_reg) && rev_reg[8*j +: 8] != window[8*j +: 8]) begin
                mismatch = 1'b1;
            end
        end
        match = !mismatch && (word_chars >= len_reg);
    end

    assign sel       = pend_reg && !prior_in;
    assign prior_out = prior_in || pend_reg;
    assign pend      = pend_reg;
    assign count     = count_reg;

    always_comb begin
        rev_next   = rev_reg;
        len_next   = len_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        pend_next  = pend_reg;
        if (hit) begin
            rev_next = '0;
            for (int j = 0; j < PATTERN_CHARS; j++) begin
                for (int k = 0; k < PATTERN_CHARS; k++) begin
                    if (j < int'(pat_len) && (k + j + 1) == int'(pat_len)) begin
                        rev_next[8*j +: 8] = pat_bytes[8*k +: 8];
                    end
                end
            end
            len_next   = pat_len;
            count_next = '0;
            flag_next  = 1'b0;
        end
        if (ctrl.char_step && active && match) begin
            flag_next = 1'b1;
        end
        if (ctrl.word_end) begin
            pend_next = flag_reg && active
                        && (32'(count_reg) < KEEP_PER_PATTERN);
            flag_next = 1'b0;
        end
        if (ctrl.advance && sel) begin
            pend_next  = 1'b0;
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rev_reg <= rev_next;
        len_reg <= len_next;
        if (!aresetn) begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: test/word_pattern_occurrence_matcher_top_tb.sv
// Testbench for word_pattern_occurrence_matcher_top: directed and random text,
// checked against a built-in predictor of the word-match reports.
// Depends on wpom_pkg and the RTL of the matcher; reads no files.
`timescale 1ns / 1ps

module word_pattern_occurrence_matcher_top_tb;

    localparam int NUM_PATTERNS  = 16;
    localparam int WINDOW_CHARS  = 4;
    localparam int OCC_LIMIT     = 10;

    // Register map and the one action code the package leaves unnamed
    localparam logic [2:0]                    ADDR_PATTERN_COUNT = 3'd0;
    localparam logic [wpom_pkg::ACTION_W-1:0] ACT_NONE           = 2'd3;

    // NUL, LF, CR, double quote, backslash and grave accent; the rest of the
    // separators are the printable marks below
    localparam logic [47:0] CTRL_SEPARATORS = {8'h60, 8'h5C, 8'h22, 8'h0D, 8'h0A, 8'h00};

    typedef struct packed {
        logic [wpom_pkg::ACTION_W-1:0] action;
        logic [7:0]                    character;
        logic [wpom_pkg::SLOT_W-1:0]   slot;
        logic [31:0]                   text;
        logic [2:0]                    length;
    } text_item_t;

    typedef struct packed {
        logic [wpom_pkg::INDEX_W-1:0] index;
        logic [wpom_pkg::POS_W-1:0]   position;
        logic [wpom_pkg::OCC_W-1:0]   occurrence;
        logic                         last;
    } match_report_t;

    typedef enum int {RX_STEADY, RX_RANDOM, RX_BURSTY} rx_mode_t;

    // ---------------------------------------------------------------------
    // Clock, reset and the block's inputs, all known from time zero
    // ---------------------------------------------------------------------
    logic                          aclk             = 1'b0;
    logic                          aresetn          = 1'b0;
    logic                          s_valid          = 1'b0;
    logic                          s_ready;
    logic [wpom_pkg::ACTION_W-1:0] s_action         = '0;
    logic [7:0]                    s_character      = '0;
    logic [wpom_pkg::SLOT_W-1:0]   s_pattern_slot   = '0;
    logic [31:0]                   s_pattern_text   = '0;
    logic [2:0]                    s_pattern_length = '0;
    logic                          m_valid;
    logic                          m_ready          = 1'b0;
    logic [wpom_pkg::INDEX_W-1:0]  m_pattern_index;
    logic [wpom_pkg::POS_W-1:0]    m_word_position;
    logic [wpom_pkg::OCC_W-1:0]    m_occurrence_number;
    logic                          m_last;
    logic                          psel             = 1'b0;
    logic                          penable          = 1'b0;
    logic                          pwrite           = 1'b0;
    logic [2:0]                    paddr            = '0;
    logic [31:0]                   pwdata           = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    always #4 aclk = ~aclk;

    word_pattern_occurrence_matcher_top #(
        .PATTERNS         (NUM_PATTERNS),
        .PATTERN_CHARS    (WINDOW_CHARS),
        .KEEP_PER_PATTERN (OCC_LIMIT)
    ) u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_action            (s_action),
        .s_character         (s_character),
        .s_pattern_slot      (s_pattern_slot),
        .s_pattern_text      (s_pattern_text),
        .s_pattern_length    (s_pattern_length),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pattern_index     (m_pattern_index),
        .m_word_position     (m_word_position),
        .m_occurrence_number (m_occurrence_number),
        .m_last              (m_last),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // ---------------------------------------------------------------------
    // Predictor state: a private copy of the pattern table, the per-pattern
    // occurrence counts, the tail of the current word and the word counter
    // ---------------------------------------------------------------------
    logic [31:0]   pat_text [NUM_PATTERNS];
    int unsigned   pat_len  [NUM_PATTERNS];
    int unsigned   occ_seen [NUM_PATTERNS];
    logic [31:0]   tail_window;
    int unsigned   word_chars;
    logic [15:0]   word_hits;
    logic [31:0]   words_seen;
    logic [4:0]    pattern_limit;

    match_report_t pending_reports[$];
    match_report_t oldest_report;
    int            mismatches = 0;

    string         punct_marks  = " !#$%&'()*+,-./:;<=>?@[]^_{|}~";
    string         word_letters = "abcdeotw";

    // Sender and receiver idling controls
    bit            tx_gaps       = 1'b0;
    int unsigned   burst_left    = 0;
    rx_mode_t      rx_mode       = RX_STEADY;
    int            hold_off_left = 0;
    int unsigned   rx_run_left   = 0;
    bit            rx_run_ready  = 1'b1;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic bit is_separator(input logic [7:0] c);
        int i;
        for (i = 0; i < 6; i++) begin
            if (c == CTRL_SEPARATORS[8*i +: 8]) begin
                return 1'b1;
            end
        end
        for (i = 0; i < punct_marks.len(); i++) begin
            if (c == punct_marks[i]) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int unsigned active_patterns();
        return (pattern_limit > NUM_PATTERNS) ? NUM_PATTERNS : pattern_limit;
    endfunction

    // Close the pending word: count it and queue one report per flagged
    // pattern that has not used up its occurrences, in index order
    function automatic void close_word();
        int unsigned   hits[$];
        int unsigned   p;
        int unsigned   i;
        match_report_t r;
        if (word_chars == 0) begin
            return;
        end
        if (words_seen != 32'hFFFF_FFFF) begin
            words_seen++;
        end
        for (p = 0; p < active_patterns(); p++) begin
            if (word_hits[p] && occ_seen[p] < OCC_LIMIT) begin
                hits.push_back(p);
            end
        end
        for (i = 0; i < hits.size(); i++) begin
            r.index      = wpom_pkg::INDEX_W'(hits[i]);
            r.position   = words_seen;
            r.occurrence = wpom_pkg::OCC_W'(occ_seen[hits[i]]);
            r.last       = (i == hits.size() - 1);
            occ_seen[hits[i]]++;
            pending_reports.push_back(r);
        end
        tail_window = '0;
        word_chars  = 0;
        word_hits   = '0;
    endfunction

    function automatic void predict_match_reports(input text_item_t it);
        logic [31:0] folded;
        int unsigned p;
        int unsigned k;
        bit          hit;
        case (it.action)
            wpom_pkg::ACT_LOAD: begin
                for (k = 0; k < 4; k++) begin
                    folded[8*k +: 8] = to_lower(it.text[8*k +: 8]);
                end
                pat_text[it.slot]  = folded;
                pat_len[it.slot]   = (it.length > WINDOW_CHARS) ? WINDOW_CHARS : it.length;
                occ_seen[it.slot]  = 0;
                word_hits[it.slot] = 1'b0;
            end
            wpom_pkg::ACT_CHAR: begin
                if (is_separator(it.character)) begin
                    close_word();
                end else begin
                    tail_window = {tail_window[23:0], to_lower(it.character)};
                    if (word_chars < WINDOW_CHARS) begin
                        word_chars++;
                    end
                    for (p = 0; p < active_patterns(); p++) begin
                        hit = (word_chars >= pat_len[p]);
                        for (k = 0; k < pat_len[p]; k++) begin
                            if (pat_text[p][8*k +: 8] != tail_window[8*(pat_len[p]-1-k) +: 8]) begin
                                hit = 1'b0;
                            end
                        end
                        if (hit) begin
                            word_hits[p] = 1'b1;
                        end
                    end
                end
            end
            wpom_pkg::ACT_END: begin
                close_word();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("MISMATCH %s at %0t: expected %0d, actual %0d", name, $realtime,
                         want, got);
            end
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------------
    // Monitor: predict on every accepted input transaction, then check every
    // accepted result transaction against the oldest queued report
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (occ_seen[i]) begin
                occ_seen[i] = 0;
            end
            tail_window   = '0;
            word_chars    = 0;
            word_hits     = '0;
            words_seen    = '0;
            pattern_limit = '0;
        end else begin
            if (s_valid && s_ready) begin
                predict_match_reports({s_action, s_character, s_pattern_slot, s_pattern_text,
                                       s_pattern_length});
            end
            if (m_valid && m_ready) begin
                if (pending_reports.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("MISMATCH at %0t: report for pattern %0d, word %0d with none due",
                                 $realtime, m_pattern_index, m_word_position);
                    end
                    mismatches++;
                end else begin
                    oldest_report = pending_reports.pop_front();
                    compare_field("pattern_index", 32'(oldest_report.index),
                                  32'(m_pattern_index));
                    compare_field("word_position", oldest_report.position, m_word_position);
                    compare_field("occurrence_number", 32'(oldest_report.occurrence),
                                  32'(m_occurrence_number));
                    compare_field("last", 32'(oldest_report.last), 32'(m_last));
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: steady, random or run-length stalls; a requested hold-off
    // overrides the mode and is counted down here on every edge
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            hold_off_left = hold_off_left - 1;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY: begin
                    m_ready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    if (rx_run_left == 0) begin
                        rx_run_ready = !rx_run_ready;
                        rx_run_left  = $urandom_range(1, 12);
                    end
                    rx_run_left--;
                    m_ready <= rx_run_ready;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sender: offer one transaction and hold it until accepted; in burst
    // mode drop valid for a random gap once the current burst is used up
    // ---------------------------------------------------------------------
    task automatic send_item(input text_item_t it);
        s_valid          <= 1'b1;
        s_action         <= it.action;
        s_character      <= it.character;
        s_pattern_slot   <= it.slot;
        s_pattern_text   <= it.text;
        s_pattern_length <= it.length;
        do @(posedge aclk); while (!s_ready);
        if (tx_gaps) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Fields the action ignores still get random values
    function automatic text_item_t filler_item(input logic [wpom_pkg::ACTION_W-1:0] act);
        text_item_t it;
        it.action    = act;
        it.character = 8'($urandom_range(0, 255));
        it.slot      = wpom_pkg::SLOT_W'($urandom_range(0, NUM_PATTERNS - 1));
        it.text      = $urandom;
        it.length    = 3'($urandom_range(0, 7));
        return it;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = word_letters[$urandom_range(0, word_letters.len() - 1)];
        if ($urandom_range(0, 2) == 0) begin
            c = c - 8'd32;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_separator();
        int unsigned roll;
        roll = $urandom_range(0, punct_marks.len() + 5);
        if (roll < punct_marks.len()) begin
            return punct_marks[roll];
        end
        return CTRL_SEPARATORS[8*(roll - punct_marks.len()) +: 8];
    endfunction

    function automatic logic [31:0] random_pattern();
        return {pick_letter(), pick_letter(), pick_letter(), pick_letter()};
    endfunction

    // Mostly words over a small alphabet so patterns hit often, with
    // separators, raw bytes, reloads, end-of-text and unknown actions mixed in
    function automatic text_item_t random_text_item();
        text_item_t  it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        it   = filler_item(wpom_pkg::ACT_CHAR);
        if (roll < 64) begin
            it.character = pick_letter();
        end else if (roll < 78) begin
            it.character = pick_separator();
        end else if (roll < 82) begin
            // raw byte, already random
        end else if (roll < 90) begin
            it.action = wpom_pkg::ACT_LOAD;
            if ($urandom_range(0, 3) != 0) begin
                it.text = random_pattern();
            end
            if ($urandom_range(0, 4) < 3) begin
                it.length = 3'($urandom_range(1, 2));
            end
        end else if (roll < 96) begin
            it.action = wpom_pkg::ACT_END;
        end else begin
            it.action = ACT_NONE;
        end
        return it;
    endfunction

    task automatic send_char(input logic [7:0] c);
        text_item_t it;
        it           = filler_item(wpom_pkg::ACT_CHAR);
        it.character = c;
        send_item(it);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    task automatic send_load(input logic [wpom_pkg::SLOT_W-1:0] slot, input logic [31:0] text,
                             input logic [2:0] len);
        text_item_t it;
        it        = filler_item(wpom_pkg::ACT_LOAD);
        it.slot   = slot;
        it.text   = text;
        it.length = len;
        send_item(it);
    endtask

    task automatic send_end();
        send_item(filler_item(wpom_pkg::ACT_END));
    endtask

    // Drop valid, wait for every queued report, then let the block settle
    task automatic wait_idle(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // Write pattern_count while idle and read it back
    task automatic write_pattern_count(input logic [4:0] value);
        wait_idle(4);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PATTERN_COUNT;
        pwdata  <= {27'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pattern_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        compare_field("pattern_count readback", {27'd0, value}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Fill every slot before any pattern becomes active: upper-case text,
    // the empty pattern, an over-long length, a high byte and a tab
    task automatic test_pattern_loading();
        int i;
        send_load(4'd0, 32'h0000_0041, 3'd1);   // "A"
        send_load(4'd1, 32'h0000_4241, 3'd2);   // "AB"
        send_load(4'd2, 32'h0074_6163, 3'd3);   // "cat"
        send_load(4'd3, 32'h4452_4F57, 3'd4);   // "WORD"
        send_load(4'd4, $urandom, 3'd0);        // empty, hits every word
        send_load(4'd5, 32'h5344_4E45, 3'd7);   // "ENDS", length cut to four
        send_load(4'd6, 32'h0000_00E9, 3'd1);
        send_load(4'd7, 32'h0000_0009, 3'd1);   // tab
        for (i = 8; i < NUM_PATTERNS; i++) begin
            send_load(wpom_pkg::SLOT_W'(i), random_pattern(), 3'($urandom_range(1, 4)));
        end
        write_pattern_count(5'd16);
    endtask

    // Tab and a high byte inside words, NUL, LF, CR, quote, backslash and comma
    // separators, runs of separators, unknown action, end of text with and without a word
    task automatic test_word_boundaries();
        send_text("CAT");
        send_char(8'h09);
        send_text("ab");
        send_char(8'h0A);
        send_char(8'hE9);
        send_text("eNdS");
        send_char(8'h00);
        send_char(",");
        send_char(8'h5C);
        send_char(8'h22);
        send_char(8'h0D);
        send_item(filler_item(ACT_NONE));
        send_text("Word");
        send_end();
        send_end();
    endtask

    // A word with no active match is still counted; a reload mid-word
    // drops that pattern's flag and restarts its occurrence count
    task automatic test_reload_and_silent_words();
        write_pattern_count(5'd4);
        send_text("zz");
        send_end();
        send_char("a");
        send_load(4'd0, 32'h0000_0061, 3'd1);
        send_end();
        send_char("a");
        send_end();
    endtask

    task automatic test_random_text(input logic [4:0] count, input int items,
                                    input bit gaps, input rx_mode_t mode);
        write_pattern_count(count);
        tx_gaps = gaps;
        rx_mode = mode;
        repeat (items) send_item(random_text_item());
    endtask

    // Hold the receiver off for a long stretch while text keeps coming, so
    // the report stage fills and the input side stalls
    task automatic test_backpressure();
        write_pattern_count(5'd16);
        send_load(4'd0, 32'h0000_0061, 3'd1);
        send_load(4'd1, 32'h0000_0065, 3'd1);
        send_load(4'd2, 32'h0000_006F, 3'd1);
        send_load(4'd3, 32'h0000_0074, 3'd1);
        tx_gaps       = 1'b0;
        rx_mode       = RX_RANDOM;
        hold_off_left = 300;
        repeat (40) send_item(random_text_item());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_pattern_loading();
        test_word_boundaries();
        test_reload_and_silent_words();
        test_random_text(5'd16, 100, 1'b0, RX_STEADY);
        test_random_text(5'd31, 100, 1'b1, RX_RANDOM);
        test_random_text(5'd0, 40, 1'b1, RX_BURSTY);
        test_random_text(5'd9, 60, 1'b1, RX_BURSTY);
        test_backpressure();
        wait_idle(20);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
